[rtl/tlbia_pkg.sv]
// shared constants and types for the two-level bitmap id allocator
package tlbia_pkg;

    localparam int NUM_GROUPS_DEF  = 32;
    localparam int GROUP_WIDTH_DEF = 32;
    localparam int ID_W            = 10;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_EXHAUSTED = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch request, start group word read
        logic commit;   // update bitmaps, load result
    } tlbia_ctl_t;

endpackage

[rtl/tlbia_datapath.sv]
// datapath: group word store, summary word, bit search and result registers
module tlbia_datapath #(
    parameter int NUM_GROUPS  = tlbia_pkg::NUM_GROUPS_DEF,
    parameter int GROUP_WIDTH = tlbia_pkg::GROUP_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tlbia_pkg::tlbia_ctl_t      ctl,
    input  logic                       cmd,
    input  logic [tlbia_pkg::ID_W-1:0] id,
    output logic [tlbia_pkg::ID_W-1:0] result_id,
    output logic                       status
);

    localparam int GRP_W = $clog2(NUM_GROUPS);
    localparam int BIT_W = $clog2(GROUP_WIDTH);
    localparam int ID_W  = tlbia_pkg::ID_W;
    localparam int POOL  = NUM_GROUPS * GROUP_WIDTH;

    logic [GROUP_WIDTH-1:0] busy_mem [NUM_GROUPS];
    logic [NUM_GROUPS-1:0]  word_valid_reg;
    logic [NUM_GROUPS-1:0]  summary_reg;

    logic                   cmd_reg;
    logic [ID_W-1:0]        id_reg;
    logic [GRP_W-1:0]       grp_reg;
    logic                   skip_reg;
    logic [GROUP_WIDTH-1:0] rd_word_reg;
    logic                   rd_valid_reg;
    logic [ID_W-1:0]        result_id_reg;
    logic                   status_reg;

    logic [GRP_W-1:0]       rel_grp;
    logic                   rel_in_pool;
    logic [GRP_W-1:0]       alloc_grp;
    logic                   alloc_none;
    logic [GRP_W-1:0]       rd_addr;

    logic [GROUP_WIDTH-1:0] cur_word;
    logic [BIT_W-1:0]       alloc_bit;
    logic [GROUP_WIDTH-1:0] alloc_mask;
    logic [BIT_W-1:0]       rel_bit;
    logic [GROUP_WIDTH-1:0] new_word;
    logic                   wr_en;

    // group of a released id: highest group base not above the id
    always_comb
    begin
        rel_grp     = '0;
        rel_in_pool = (32'(id) < 32'(POOL));
        for (int g = 1; g < NUM_GROUPS; g++)
        begin
            if (32'(id) >= 32'(g * GROUP_WIDTH))
            begin
                rel_grp = GRP_W'(g);
            end
        end
    end

    // lowest group not marked full
    always_comb
    begin
        alloc_grp  = '0;
        alloc_none = &summary_reg;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (!summary_reg[g])
            begin
                alloc_grp = GRP_W'(g);
            end
        end
    end

    assign rd_addr = (cmd == tlbia_pkg::CMD_RELEASE) ? rel_grp : alloc_grp;

    // never-written words read as zero
    assign cur_word = rd_valid_reg ? rd_word_reg : '0;

    // lowest free bit in the group word
    always_comb
    begin
        alloc_bit  = '0;
        alloc_mask = '0;
        for (int b = GROUP_WIDTH - 1; b >= 0; b--)
        begin
            if (!cur_word[b])
            begin
                alloc_bit  = BIT_W'(b);
                alloc_mask = GROUP_WIDTH'(1) << b;
            end
        end
    end

    assign rel_bit = BIT_W'(32'(id_reg) - 32'(grp_reg) * GROUP_WIDTH);

    always_comb
    begin
        if (cmd_reg == tlbia_pkg::CMD_RELEASE)
        begin
            new_word = cur_word & ~(GROUP_WIDTH'(1) << rel_bit);
        end
        else
        begin
            new_word = cur_word | alloc_mask;
        end
    end

    assign wr_en = ctl.commit && !skip_reg;

    // group word store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            busy_mem[grp_reg] <= new_word;
        end
        if (ctl.capture)
        begin
            rd_word_reg <= busy_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            summary_reg    <= '0;
        end
        else if (wr_en)
        begin
            word_valid_reg[grp_reg] <= 1'b1;
            if (cmd_reg == tlbia_pkg::CMD_RELEASE)
            begin
                summary_reg[grp_reg] <= 1'b0;
            end
            else if (&new_word)
            begin
                summary_reg[grp_reg] <= 1'b1;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg      <= cmd;
            id_reg       <= id;
            grp_reg      <= rd_addr;
            skip_reg     <= (cmd == tlbia_pkg::CMD_RELEASE) ? !rel_in_pool : alloc_none;
            rd_valid_reg <= word_valid_reg[rd_addr];
        end
        if (ctl.commit)
        begin
            if (cmd_reg == tlbia_pkg::CMD_RELEASE)
            begin
                result_id_reg <= id_reg;
                status_reg    <= tlbia_pkg::STATUS_OK;
            end
            else if (skip_reg)
            begin
                result_id_reg <= '0;
                status_reg    <= tlbia_pkg::STATUS_EXHAUSTED;
            end
            else
            begin
                result_id_reg <= ID_W'(32'(grp_reg) * GROUP_WIDTH + 32'(alloc_bit));
                status_reg    <= tlbia_pkg::STATUS_OK;
            end
        end
    end

    assign result_id = result_id_reg;
    assign status    = status_reg;

endmodule

[rtl/tlbia_ctrl.sv]
// controller: request/response handshake and two-step sequencing
module tlbia_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output tlbia_pkg::tlbia_ctl_t ctl
);

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    // take a request only in idle and when the response slot is empty or drains now
    assign req_stall   = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign ctl.capture = req_valid && !req_stall;
    assign ctl.commit  = (state_reg == ST_UPDATE);

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.capture)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next     = ST_IDLE;
                rsp_valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

[rtl/two_level_bitmap_id_allocator.sv]
// top level of the two-level bitmap id allocator
// Allocates and frees ids from a pool of NUM_GROUPS * GROUP_WIDTH (1024 by
// default). Each request transaction (cmd, id) yields exactly one response
// transaction (result_id, status). cmd allocate returns the lowest free id
// from the lowest group that is not full, or result_id 0 with status 1 when
// the pool is exhausted; cmd release frees the given id (no in-use check) and
// echoes it with status 0. In the accept cycle the target group is chosen
// from the summary word and its busy word is read from the group store, and
// in the next cycle the free bit is found, the word written back and the
// response loaded. The dependence through that read-modify-write means a new
// request is not taken while the previous one is in its update step. A new
// request is taken while the previous response waits, as long as it is taken
// by the accept edge. No clearing pass is needed after reset; per-group valid
// flags make the pool empty at once.
module two_level_bitmap_id_allocator #(
    parameter int NUM_GROUPS  = tlbia_pkg::NUM_GROUPS_DEF,
    parameter int GROUP_WIDTH = tlbia_pkg::GROUP_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // request channel
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic                       cmd,
    input  logic [tlbia_pkg::ID_W-1:0] id,
    // response channel
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [tlbia_pkg::ID_W-1:0] result_id,
    output logic                       status
);

    tlbia_pkg::tlbia_ctl_t ctl;

    // sequencing and handshakes
    tlbia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    // bitmaps, search logic and response payload
    tlbia_datapath #(
        .NUM_GROUPS  (NUM_GROUPS),
        .GROUP_WIDTH (GROUP_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cmd       (cmd),
        .id        (id),
        .result_id (result_id),
        .status    (status)
    );

endmodule

[verif/tlbia_tb_pkg.sv]
// scoreboard with a bitmap pool predictor for the id allocator testbench
package tlbia_tb_pkg;

    localparam int POOL_GROUPS = tlbia_pkg::NUM_GROUPS_DEF;
    localparam int POOL_WIDTH  = tlbia_pkg::GROUP_WIDTH_DEF;
    localparam int POOL_IDS    = POOL_GROUPS * POOL_WIDTH;

    typedef struct packed {
        logic [tlbia_pkg::ID_W-1:0] result_id;
        logic                       status;
    } id_answer_t;

    class id_pool_scoreboard;

        logic [POOL_GROUPS-1:0] full_mask;
        logic [POOL_WIDTH-1:0]  busy_map [POOL_GROUPS];
        id_answer_t             answers_due [$];
        int unsigned            mismatches;

        function new();
            full_mask = '0;
            foreach (busy_map[g])
                busy_map[g] = '0;
            mismatches = 0;
        endfunction

        // advance the pool copy by one request and return the answer it earns
        function id_answer_t predict_answer(logic op, logic [tlbia_pkg::ID_W-1:0] rid);
            id_answer_t ans;
            int         g;
            int         b;
            int         free_bit;
            bit         placed;
            ans.result_id = rid;
            ans.status    = tlbia_pkg::STATUS_OK;
            if (op == tlbia_pkg::CMD_ALLOC)
            begin
                ans.result_id = '0;
                ans.status    = tlbia_pkg::STATUS_EXHAUSTED;
                placed        = 1'b0;
                for (g = 0; g < POOL_GROUPS && !placed; g++)
                begin
                    if (!full_mask[g])
                    begin
                        free_bit = -1;
                        for (b = POOL_WIDTH - 1; b >= 0; b--)
                            if (!busy_map[g][b])
                                free_bit = b;
                        if (free_bit < 0)
                        begin
                            // stale summary bit: mark the group full, move on
                            full_mask[g] = 1'b1;
                        end
                        else
                        begin
                            busy_map[g][free_bit] = 1'b1;
                            if (&busy_map[g])
                                full_mask[g] = 1'b1;
                            ans.result_id = tlbia_pkg::ID_W'(g * POOL_WIDTH + free_bit);
                            ans.status    = tlbia_pkg::STATUS_OK;
                            placed        = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                g = rid / POOL_WIDTH;
                b = rid % POOL_WIDTH;
                if (g < POOL_GROUPS)
                begin
                    busy_map[g][b] = 1'b0;
                    full_mask[g]   = 1'b0;
                end
            end
            return ans;
        endfunction

        function void note_request(logic op, logic [tlbia_pkg::ID_W-1:0] rid);
            answers_due.push_back(predict_answer(op, rid));
        endfunction

        function void check_answer(logic [tlbia_pkg::ID_W-1:0] got_id, logic got_status);
            id_answer_t exp;
            if (answers_due.size() == 0)
            begin
                $display("%0t: response with no request pending: result_id %0d status %0d",
                         $time, got_id, got_status);
                mismatches++;
                return;
            end
            exp = answers_due.pop_front();
            if (got_id !== exp.result_id)
            begin
                $display("%0t: result_id mismatch: expected %0d, actual %0d",
                         $time, exp.result_id, got_id);
                mismatches++;
            end
            if (got_status !== exp.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, exp.status, got_status);
                mismatches++;
            end
        endfunction

        function int answers_pending();
            return answers_due.size();
        endfunction

        function bit pool_exhausted();
            return &full_mask;
        endfunction

        // some id that is busy right now, scanning from a random point; the start id when none is busy
        function logic [tlbia_pkg::ID_W-1:0] pick_busy_id();
            int start;
            int k;
            int n;
            start = $urandom_range(0, POOL_IDS - 1);
            for (k = 0; k < POOL_IDS; k++)
            begin
                n = (start + k) % POOL_IDS;
                if (busy_map[n / POOL_WIDTH][n % POOL_WIDTH])
                    return tlbia_pkg::ID_W'(n);
            end
            return tlbia_pkg::ID_W'(start);
        endfunction

    endclass

endpackage

[verif/tb_two_level_bitmap_id_allocator.sv]
// testbench for the two-level bitmap id allocator
module tb_two_level_bitmap_id_allocator;

    // cycles with no transaction on either channel before the run is called hung
    localparam int HANG_LIMIT = 400;

    logic                       clk;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_stall;
    logic                       cmd;
    logic [tlbia_pkg::ID_W-1:0] id;
    logic                       rsp_valid;
    logic                       rsp_stall;
    logic [tlbia_pkg::ID_W-1:0] result_id;
    logic                       status;

    tlbia_tb_pkg::id_pool_scoreboard sb = new();

    // calm: last stretch of the run, no idling on either side
    bit calm;
    bit req_bursty;
    bit rsp_bursty;
    int requests_sent;
    int quiet_cycles;

    two_level_bitmap_id_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .id        (id),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .result_id (result_id),
        .status    (status)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [tlbia_pkg::ID_W-1:0] any_id();
        return tlbia_pkg::ID_W'($urandom_range(0, (1 << tlbia_pkg::ID_W) - 1));
    endfunction

    // present one request transaction and hold it until taken; the stall is
    // sampled at the falling edge, where every input has long settled
    task automatic issue(input logic op, input logic [tlbia_pkg::ID_W-1:0] rid);
        bit taken;
        req_valid <= 1'b1;
        cmd       <= op;
        id        <= rid;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        sb.note_request(op, rid);
        requests_sent++;
        // switch between bursty and steady stretches now and then
        if (requests_sent % 40 == 0)
            req_bursty = $urandom_range(0, 2) != 0;
        if (!calm && req_bursty && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // one random request: alloc_pct percent allocates, the rest releases,
    // mostly of ids in use and sometimes of any id at all
    task automatic churn_item(input int alloc_pct);
        if ($urandom_range(1, 100) <= alloc_pct)
            issue(tlbia_pkg::CMD_ALLOC, any_id());
        else if ($urandom_range(0, 4) != 0)
            issue(tlbia_pkg::CMD_RELEASE, sb.pick_busy_id());
        else
            issue(tlbia_pkg::CMD_RELEASE, any_id());
    endtask

    // hold off new requests until every response is back
    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.answers_pending() != 0)
            @(posedge clk);
    endtask

    // response side: random stall bursts, steady stretches, none when calm
    initial
    begin
        rsp_stall  <= 1'b0;
        rsp_bursty = 1'b1;
        @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (!calm && rst_n && rsp_bursty && $urandom_range(0, 5) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            if ($urandom_range(0, 49) == 0)
                rsp_bursty = $urandom_range(0, 2) != 0;
        end
    end

    // response checking and hang watchdog, both sampled mid-cycle
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_answer(result_id, status);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("tb_two_level_bitmap_id_allocator: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int fill_guard;
        calm          = 1'b0;
        req_bursty    = 1'b1;
        requests_sent = 0;
        quiet_cycles  = 0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        cmd       <= tlbia_pkg::CMD_ALLOC;
        id        <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lowest-first allocation, reuse of a freed id, id field
        // ignored on allocate, release of free ids at both ends of the range
        issue(tlbia_pkg::CMD_ALLOC, '0);
        issue(tlbia_pkg::CMD_ALLOC, '1);
        issue(tlbia_pkg::CMD_ALLOC, '0);
        issue(tlbia_pkg::CMD_RELEASE, tlbia_pkg::ID_W'(1));
        issue(tlbia_pkg::CMD_ALLOC, '0);
        issue(tlbia_pkg::CMD_RELEASE, '1);
        issue(tlbia_pkg::CMD_RELEASE, '0);
        issue(tlbia_pkg::CMD_RELEASE, '0);
        issue(tlbia_pkg::CMD_ALLOC, '0);
        issue(tlbia_pkg::CMD_RELEASE, tlbia_pkg::ID_W'('h2aa));
        issue(tlbia_pkg::CMD_RELEASE, tlbia_pkg::ID_W'('h155));
        issue(tlbia_pkg::CMD_ALLOC, tlbia_pkg::ID_W'('h155));
        issue(tlbia_pkg::CMD_RELEASE, tlbia_pkg::ID_W'(2));
        issue(tlbia_pkg::CMD_ALLOC, '1);

        // mixed traffic on a lightly used pool
        repeat (30) churn_item(70);

        // let the pipeline empty completely before the next stretch
        drain_responses();

        // fill the pool: groups go full one after another, summary bits set
        fill_guard = 0;
        while (!sb.pool_exhausted() && fill_guard < 3000)
        begin
            churn_item(99);
            fill_guard++;
        end

        // full pool: exhausted answers, a hole punched and refilled, and
        // releases of arbitrary ids
        repeat (8)
        begin
            issue(tlbia_pkg::CMD_ALLOC, any_id());
            if ($urandom_range(0, 3) == 0)
                issue(tlbia_pkg::CMD_RELEASE, any_id());
            else
                issue(tlbia_pkg::CMD_RELEASE, sb.pick_busy_id());
            repeat ($urandom_range(1, 2)) issue(tlbia_pkg::CMD_ALLOC, any_id());
        end

        // thin the pool out again, clearing summary bits across groups
        repeat (30) churn_item(25);

        // last stretch with no idling on either side
        calm = 1'b1;
        repeat (30) churn_item(50);

        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.answers_pending() != 0)
            @(posedge clk);
        // a few more cycles to catch any stray response
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.answers_pending() == 0)
            $display("tb_two_level_bitmap_id_allocator: PASS");
        else
            $display("tb_two_level_bitmap_id_allocator: FAIL");
        $finish;
    end

endmodule

[two_level_bitmap_id_allocator.f]
rtl/tlbia_pkg.sv
rtl/tlbia_datapath.sv
rtl/tlbia_ctrl.sv
rtl/two_level_bitmap_id_allocator.sv
verif/tlbia_tb_pkg.sv
verif/tb_two_level_bitmap_id_allocator.sv
